// ===== hw/rtl/qrm_pkg.sv =====
// shared types, widths and constants for the quaternion to rotation matrix unit
`default_nettype none
package qrm_pkg;

  // field widths
  localparam int COMP_W = 16;
  localparam int ELEM_W = 16;
  localparam int LIM_W  = 32;
  localparam int CFG_IDX_W = 1;

  // internal arithmetic widths
  localparam int PROD_W = 2 * COMP_W;          // one product of two components
  localparam int NORM_W = PROD_W + 1;          // squared norm, at most 2^32
  localparam int NUM_W  = PROD_W + 2;          // signed numerator, at most 2^32 in magnitude
  localparam int MAG_W  = NUM_W - 1;           // numerator magnitude
  localparam int DEN_W  = NORM_W + 1;          // divisor is twice the norm
  localparam int QUO_W  = ELEM_W - 1;          // quotient never exceeds 2^14
  localparam int DVD_W  = DEN_W + QUO_W;       // dividend width
  localparam int TRY_W  = DEN_W + 2;           // trial subtract with borrow bit

  // pipeline shape
  localparam int LANES      = 9;
  localparam int DIV_STAGES = QUO_W;
  localparam int PIPE_LAT   = 2 + 1 + DIV_STAGES + 1;

  // largest quotient magnitude for a unit entry
  localparam logic [QUO_W-1:0] QUO_ONE = QUO_W'(1 << (ELEM_W - 2));

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_HIGH = 1'b1;
  localparam logic [LIM_W-1:0] NORM_LOW_RST  = 32'd6710886;
  localparam logic [LIM_W-1:0] NORM_HIGH_RST = 32'd671088640;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic        [LIM_W-1:0]  lim_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef num_t  [LANES-1:0] num_vec_t;
  typedef elem_t [LANES-1:0] elem_vec_t;

  // output of the product and sum stages
  typedef struct packed {
    logic                valid;
    logic [NORM_W-1:0]   norm;
    num_vec_t            num;
  } front_t;

  // one divider lane: sign, partial remainder, dividend bits / quotient bits
  typedef struct packed {
    logic              neg;
    logic [DEN_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } lane_t;

  typedef lane_t [LANES-1:0] lane_vec_t;

  // control that travels alongside the divider lanes
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              norm_ok;
    logic [DEN_W-1:0]  den;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qrm_front.sv =====
// component products and the squared norm and matrix numerators, two stages
`default_nettype none
module qrm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  qrm_pkg::comp_t  comp_w,
  input  qrm_pkg::comp_t  comp_x,
  input  qrm_pkg::comp_t  comp_y,
  input  qrm_pkg::comp_t  comp_z,
  output qrm_pkg::front_t front_out
);
  import qrm_pkg::*;

  logic                     v1_r;
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, wy_r, wz_r, xy_r, xz_r, yz_r;
  logic signed [NUM_W-1:0]  e_ww, e_xx, e_yy, e_zz, e_wx, e_wy, e_wz, e_xy, e_xz, e_yz;
  logic signed [NUM_W-1:0]  n_sum;
  front_t                   front_nxt;
  front_t                   front_r;

  // stage 1: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  // stage 1: the ten products
  always_ff @(posedge clk) begin
    ww_r <= comp_w * comp_w;
    xx_r <= comp_x * comp_x;
    yy_r <= comp_y * comp_y;
    zz_r <= comp_z * comp_z;
    wx_r <= comp_w * comp_x;
    wy_r <= comp_w * comp_y;
    wz_r <= comp_w * comp_z;
    xy_r <= comp_x * comp_y;
    xz_r <= comp_x * comp_z;
    yz_r <= comp_y * comp_z;
  end

  // stage 2: norm and numerators
  always_comb begin
    e_ww = NUM_W'(ww_r);
    e_xx = NUM_W'(xx_r);
    e_yy = NUM_W'(yy_r);
    e_zz = NUM_W'(zz_r);
    e_wx = NUM_W'(wx_r);
    e_wy = NUM_W'(wy_r);
    e_wz = NUM_W'(wz_r);
    e_xy = NUM_W'(xy_r);
    e_xz = NUM_W'(xz_r);
    e_yz = NUM_W'(yz_r);
    n_sum = e_ww + e_xx + e_yy + e_zz;
    front_nxt.valid  = v1_r;
    front_nxt.norm   = n_sum[NORM_W-1:0];
    front_nxt.num[0] = e_ww + e_xx - e_yy - e_zz;
    front_nxt.num[1] = (e_xy + e_wz) <<< 1;
    front_nxt.num[2] = (e_xz - e_wy) <<< 1;
    front_nxt.num[3] = (e_xy - e_wz) <<< 1;
    front_nxt.num[4] = e_ww - e_xx + e_yy - e_zz;
    front_nxt.num[5] = (e_yz + e_wx) <<< 1;
    front_nxt.num[6] = (e_xz + e_wy) <<< 1;
    front_nxt.num[7] = (e_yz - e_wx) <<< 1;
    front_nxt.num[8] = e_ww - e_xx - e_yy + e_zz;
  end

  // stage 2 register, valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
    front_r.norm <= front_nxt.norm;
    front_r.num  <= front_nxt.num;
  end

  assign front_out = front_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qrm_div_stage.sv =====
// one restoring division step for all nine lanes, one quotient bit per stage
`default_nettype none
module qrm_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  qrm_pkg::div_ctl_t   ctl_in,
  input  qrm_pkg::lane_vec_t  lanes_in,
  output qrm_pkg::div_ctl_t   ctl_out,
  output qrm_pkg::lane_vec_t  lanes_out
);
  import qrm_pkg::*;

  logic [TRY_W-1:0] trial;
  logic [DEN_W:0]   shifted;
  lane_vec_t        lanes_nxt;
  div_ctl_t         ctl_r;
  lane_vec_t        lanes_r;

  // shift in the next dividend bit, subtract the divisor if it fits
  always_comb begin
    trial   = '0;
    shifted = '0;
    for (int l = 0; l < LANES; l++) begin
      shifted = {lanes_in[l].rem, lanes_in[l].quo[QUO_W-1]};
      trial   = {1'b0, shifted} - {2'b00, ctl_in.den};
      lanes_nxt[l].neg = lanes_in[l].neg;
      if (!trial[TRY_W-1]) begin
        lanes_nxt[l].rem = trial[DEN_W-1:0];
        lanes_nxt[l].quo = {lanes_in[l].quo[QUO_W-2:0], 1'b1};
      end else begin
        lanes_nxt[l].rem = shifted[DEN_W-1:0];
        lanes_nxt[l].quo = {lanes_in[l].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  // stage register, valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.zero    <= ctl_in.zero;
    ctl_r.norm_ok <= ctl_in.norm_ok;
    ctl_r.den     <= ctl_in.den;
    lanes_r       <= lanes_nxt;
  end

  assign ctl_out   = ctl_r;
  assign lanes_out = lanes_r;

endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_to_rotation_matrix_unit.sv =====
// quaternion to 3x3 rotation matrix: config registers, divider setup, divider chain, output
// pipeline: results strobe after the transaction passes 2 product/sum stages,
//   1 divider setup stage, 15 one-bit division stages and 1 output stage
// throughput: one quaternion per cycle while busy is low; the 15-stage divider chain fixes the latency
// busy is high only during reset; results cannot be held off by the receiver
// reset: synchronous active-low rst_n clears all valid bits and loads the default limits
`default_nettype none
module quaternion_to_rotation_matrix_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input transaction
  input  logic                               start,
  output logic                               busy,
  input  qrm_pkg::comp_t                     in_comp_w,
  input  qrm_pkg::comp_t                     in_comp_x,
  input  qrm_pkg::comp_t                     in_comp_y,
  input  qrm_pkg::comp_t                     in_comp_z,
  // result transaction
  output logic                               out_strobe,
  output qrm_pkg::elem_t                     out_elem_00,
  output qrm_pkg::elem_t                     out_elem_01,
  output qrm_pkg::elem_t                     out_elem_02,
  output qrm_pkg::elem_t                     out_elem_10,
  output qrm_pkg::elem_t                     out_elem_11,
  output qrm_pkg::elem_t                     out_elem_12,
  output qrm_pkg::elem_t                     out_elem_20,
  output qrm_pkg::elem_t                     out_elem_21,
  output qrm_pkg::elem_t                     out_elem_22,
  output logic                               out_norm_ok,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  qrm_pkg::lim_t                      cfg_data
);
  import qrm_pkg::*;

  logic        busy_r;
  logic        in_accept;
  lim_t        low_lim_r, high_lim_r;
  front_t      front;

  div_ctl_t    prep_ctl_nxt, prep_ctl_r;
  lane_vec_t   prep_lanes_nxt, prep_lanes_r;
  num_t        num_l;
  num_t        mag_full;
  logic [DVD_W-1:0] dividend;

  div_ctl_t    ctl_s   [0:DIV_STAGES];
  lane_vec_t   lanes_s [0:DIV_STAGES];

  logic        out_strobe_r, out_strobe_nxt;
  logic        out_norm_ok_r, out_norm_ok_nxt;
  elem_vec_t   out_elem_r, out_elem_nxt;
  elem_t       mag16;
  logic        quo_ok;

  // busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start && !busy_r;
  assign cfg_ready = 1'b1;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_lim_r  <= NORM_LOW_RST;
      high_lim_r <= NORM_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NORM_LOW:  low_lim_r  <= cfg_data;
        CFG_NORM_HIGH: high_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // products, norm and numerators
  qrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_accept),
    .comp_w    (in_comp_w),
    .comp_x    (in_comp_x),
    .comp_y    (in_comp_y),
    .comp_z    (in_comp_z),
    .front_out (front)
  );

  // divider setup: magnitudes, rounding offset, limit check
  always_comb begin
    num_l    = '0;
    mag_full = '0;
    dividend = '0;
    prep_ctl_nxt.valid   = front.valid;
    prep_ctl_nxt.zero    = (front.norm == '0);
    prep_ctl_nxt.norm_ok = (front.norm != '0) &&
                           (front.norm >= NORM_W'(low_lim_r)) &&
                           (front.norm <= NORM_W'(high_lim_r));
    prep_ctl_nxt.den     = {front.norm, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      num_l    = $signed(front.num[l]);
      mag_full = num_l[NUM_W-1] ? -num_l : num_l;
      // (2*mag*2^14 + n) / (2n) rounds to nearest, ties away from zero
      dividend = DVD_W'({mag_full[MAG_W-1:0], {QUO_W{1'b0}}}) + DVD_W'(front.norm);
      prep_lanes_nxt[l].neg = num_l[NUM_W-1];
      prep_lanes_nxt[l].rem = dividend[DVD_W-1 -: DEN_W];
      prep_lanes_nxt[l].quo = dividend[QUO_W-1:0];
    end
  end

  // setup register, valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_ctl_r.valid <= 1'b0;
    end else begin
      prep_ctl_r.valid <= prep_ctl_nxt.valid;
    end
    prep_ctl_r.zero    <= prep_ctl_nxt.zero;
    prep_ctl_r.norm_ok <= prep_ctl_nxt.norm_ok;
    prep_ctl_r.den     <= prep_ctl_nxt.den;
    prep_lanes_r       <= prep_lanes_nxt;
  end

  assign ctl_s[0]   = prep_ctl_r;
  assign lanes_s[0] = prep_lanes_r;

  // divider chain
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    qrm_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    (ctl_s[s]),
      .lanes_in  (lanes_s[s]),
      .ctl_out   (ctl_s[s+1]),
      .lanes_out (lanes_s[s+1])
    );
  end

  // apply sign, force zero matrix on zero norm
  always_comb begin
    mag16  = '0;
    quo_ok = 1'b1;
    out_strobe_nxt  = ctl_s[DIV_STAGES].valid;
    out_norm_ok_nxt = ctl_s[DIV_STAGES].norm_ok;
    for (int l = 0; l < LANES; l++) begin
      mag16 = {1'b0, lanes_s[DIV_STAGES][l].quo};
      if (lanes_s[DIV_STAGES][l].quo > QUO_ONE) begin
        quo_ok = 1'b0;
      end
      if (ctl_s[DIV_STAGES].zero) begin
        out_elem_nxt[l] = '0;
      end else if (lanes_s[DIV_STAGES][l].neg) begin
        out_elem_nxt[l] = -mag16;
      end else begin
        out_elem_nxt[l] = mag16;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_norm_ok_r <= out_norm_ok_nxt;
    out_elem_r    <= out_elem_nxt;
  end

  assign out_strobe  = out_strobe_r;
  assign out_norm_ok = out_norm_ok_r;
  assign out_elem_00 = out_elem_r[0];
  assign out_elem_01 = out_elem_r[1];
  assign out_elem_02 = out_elem_r[2];
  assign out_elem_10 = out_elem_r[3];
  assign out_elem_11 = out_elem_r[4];
  assign out_elem_12 = out_elem_r[5];
  assign out_elem_20 = out_elem_r[6];
  assign out_elem_21 = out_elem_r[7];
  assign out_elem_22 = out_elem_r[8];

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##PIPE_LAT out_strobe)
    else $error("result strobe missing after pipeline latency");

  // quotients of a nonzero norm never exceed one
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_s[DIV_STAGES].valid && !ctl_s[DIV_STAGES].zero) |-> quo_ok)
    else $error("divider quotient above unit range");

  // a norm inside the limits gives a nonzero first row
  a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_norm_ok) |->
      (out_elem_00 != '0 || out_elem_01 != '0 || out_elem_02 != '0))
    else $error("zero matrix row with valid norm");

  // strobe only follows a divider-chain transaction
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(prep_ctl_r.valid, DIV_STAGES + 1))
    else $error("result strobe without matching setup transaction");

endmodule
`default_nettype wire

// ===== bench/quaternion_to_rotation_matrix_unit_tb.sv =====
// self-checking testbench for the quaternion to rotation matrix unit
`default_nettype none
module quaternion_to_rotation_matrix_unit_tb;
  import qrm_pkg::*;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  typedef struct packed {
    elem_vec_t elems;
    logic      norm_ok;
  } matrix_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  comp_t in_comp_w = '0;
  comp_t in_comp_x = '0;
  comp_t in_comp_y = '0;
  comp_t in_comp_z = '0;
  logic out_strobe;
  elem_t out_elem_00, out_elem_01, out_elem_02;
  elem_t out_elem_10, out_elem_11, out_elem_12;
  elem_t out_elem_20, out_elem_21, out_elem_22;
  logic out_norm_ok;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  lim_t cfg_data = '0;

  quaternion_to_rotation_matrix_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_comp_w   (in_comp_w),
    .in_comp_x   (in_comp_x),
    .in_comp_y   (in_comp_y),
    .in_comp_z   (in_comp_z),
    .out_strobe  (out_strobe),
    .out_elem_00 (out_elem_00),
    .out_elem_01 (out_elem_01),
    .out_elem_02 (out_elem_02),
    .out_elem_10 (out_elem_10),
    .out_elem_11 (out_elem_11),
    .out_elem_12 (out_elem_12),
    .out_elem_20 (out_elem_20),
    .out_elem_21 (out_elem_21),
    .out_elem_22 (out_elem_22),
    .out_norm_ok (out_norm_ok),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // clock, period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  quat_t   pending_quats [$];
  matrix_t expected_matrices [$];
  lim_t    limit_low  = NORM_LOW_RST;
  lim_t    limit_high = NORM_HIGH_RST;
  int      sender_idle_pct = 0;
  int      error_count = 0;
  int      quats_accepted = 0;
  int      matrices_checked = 0;
  int      zero_norm_seen = 0;
  int      in_limits_seen = 0;
  int      config_writes = 0;
  quat_t   taken_quat;
  quat_t   next_quat;
  matrix_t seen_matrix;
  matrix_t want_matrix;
  matrix_t check_matrix;
  string   elem_names [LANES] = '{"elem_00", "elem_01", "elem_02", "elem_10", "elem_11",
                                  "elem_12", "elem_20", "elem_21", "elem_22"};

  // round(num * 2^14 / den), ties away from zero, saturated to the entry range
  function automatic elem_t scaled_quotient(longint num, longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = ((mag <<< (ELEM_W - 2)) * 2 + den) / (den * 2);
    if (num < 0) begin
      return (quo > 32768) ? elem_t'(-32768) : elem_t'(-quo);
    end
    return (quo > 32767) ? elem_t'(32767) : elem_t'(quo);
  endfunction

  // expected matrix and norm flag for one quaternion under the current limits
  function automatic matrix_t rotation_of(quat_t q);
    longint w, x, y, z;
    longint ww, xx, yy, zz, wx, wy, wz, xy, xz, yz, norm;
    longint nums [LANES];
    matrix_t m;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    wx = w * x;
    wy = w * y;
    wz = w * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    norm = ww + xx + yy + zz;
    m = '0;
    if (norm == 0) begin
      return m;
    end
    nums[0] = ww + xx - yy - zz;
    nums[1] = 2 * (xy + wz);
    nums[2] = 2 * (xz - wy);
    nums[3] = 2 * (xy - wz);
    nums[4] = ww - xx + yy - zz;
    nums[5] = 2 * (yz + wx);
    nums[6] = 2 * (xz + wy);
    nums[7] = 2 * (yz - wx);
    nums[8] = ww - xx - yy + zz;
    for (int k = 0; k < LANES; k++) begin
      m.elems[k] = scaled_quotient(nums[k], norm);
    end
    m.norm_ok = (norm >= longint'(limit_low)) && (norm <= longint'(limit_high));
    return m;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
    error_count++;
  endtask

  // input driver: holds the oldest pending quaternion until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken_quat = pending_quats.pop_front();
        want_matrix = rotation_of(taken_quat);
        expected_matrices.insert(expected_matrices.size(), want_matrix);
        quats_accepted++;
        if (taken_quat == '0) zero_norm_seen++;
        if (want_matrix.norm_ok) in_limits_seen++;
      end
      if (!(start && busy)) begin
        if (pending_quats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_quat = pending_quats[0];
          start <= 1'b1;
          in_comp_w <= next_quat.w;
          in_comp_x <= next_quat.x;
          in_comp_y <= next_quat.y;
          in_comp_z <= next_quat.z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each strobed transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen_matrix.elems[0] = out_elem_00;
      seen_matrix.elems[1] = out_elem_01;
      seen_matrix.elems[2] = out_elem_02;
      seen_matrix.elems[3] = out_elem_10;
      seen_matrix.elems[4] = out_elem_11;
      seen_matrix.elems[5] = out_elem_12;
      seen_matrix.elems[6] = out_elem_20;
      seen_matrix.elems[7] = out_elem_21;
      seen_matrix.elems[8] = out_elem_22;
      seen_matrix.norm_ok = out_norm_ok;
      if (expected_matrices.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        error_count++;
      end else begin
        check_matrix = expected_matrices.pop_front();
        matrices_checked++;
        for (int k = 0; k < LANES; k++) begin
          if (seen_matrix.elems[k] !== check_matrix.elems[k]) begin
            report_mismatch(elem_names[k], seen_matrix.elems[k], check_matrix.elems[k]);
          end
        end
        if (seen_matrix.norm_ok !== check_matrix.norm_ok) begin
          report_mismatch("norm_ok", seen_matrix.norm_ok, check_matrix.norm_ok);
        end
      end
    end
  end

  task automatic queue_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = comp_t'(w);
    q.x = comp_t'(x);
    q.y = comp_t'(y);
    q.z = comp_t'(z);
    pending_quats.insert(pending_quats.size(), q);
  endtask

  function automatic comp_t pick_extreme();
    int vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
    return comp_t'(vals[$urandom_range(5)]);
  endfunction

  // mix of full-range, near-unit, small, single-axis and extreme quaternions
  task automatic queue_random_quats(input int count);
    quat_t q;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        q = quat_t'({$urandom, $urandom});
      end else if (pick < 60) begin
        q.w = comp_t'(int'($urandom_range(16384)) - 8192);
        q.x = comp_t'(int'($urandom_range(16384)) - 8192);
        q.y = comp_t'(int'($urandom_range(16384)) - 8192);
        q.z = comp_t'(int'($urandom_range(16384)) - 8192);
      end else if (pick < 75) begin
        q.w = comp_t'(int'($urandom_range(4095)) - 2048);
        q.x = comp_t'(int'($urandom_range(4095)) - 2048);
        q.y = comp_t'(int'($urandom_range(4095)) - 2048);
        q.z = comp_t'(int'($urandom_range(4095)) - 2048);
      end else if (pick < 85) begin
        q = '0;
        case ($urandom_range(3))
          0: q.w = comp_t'($urandom);
          1: q.x = comp_t'($urandom);
          2: q.y = comp_t'($urandom);
          default: q.z = comp_t'($urandom);
        endcase
      end else begin
        q.w = pick_extreme();
        q.x = pick_extreme();
        q.y = pick_extreme();
        q.z = pick_extreme();
      end
      pending_quats.insert(pending_quats.size(), q);
    end
  endtask

  // sender holds off until every expected result has come back
  task automatic wait_for_drain();
    while (pending_quats.size() != 0 || expected_matrices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one configuration transaction, valid lowered once it has been accepted
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input lim_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_NORM_LOW) limit_low = value;
    else limit_high = value;
    config_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input lim_t lo, input lim_t hi);
    write_limit(CFG_NORM_LOW, lo);
    write_limit(CFG_NORM_HIGH, hi);
  endtask

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed set under the reset limits
    sender_idle_pct = 36;
    queue_quat(0, 0, 0, 0);
    queue_quat(8192, 0, 0, 0);
    queue_quat(-8192, 0, 0, 0);
    queue_quat(0, 8192, 0, 0);
    queue_quat(0, 0, 8192, 0);
    queue_quat(0, 0, 0, 8192);
    queue_quat(5793, 5793, 0, 0);
    queue_quat(4096, 4096, 4096, 4096);
    queue_quat(32767, 32767, 32767, 32767);
    queue_quat(-32768, -32768, -32768, -32768);
    queue_quat(32767, -32768, 32767, -32768);
    queue_quat(-32768, 0, 0, 0);
    queue_quat(0, -32768, 0, 0);
    queue_quat(0, 0, -32768, 0);
    queue_quat(0, 0, 0, -32768);
    queue_quat(1, 0, 0, 0);
    queue_quat(0, 0, 0, 1);
    queue_quat(1, 1, 1, 1);
    queue_quat(-1, 1, -1, 1);
    // just below and above the default low and high limits
    queue_quat(2590, 0, 0, 0);
    queue_quat(2591, 0, 0, 0);
    queue_quat(25905, 0, 0, 0);
    queue_quat(25906, 0, 0, 0);
    queue_random_quats(330);
    wait_for_drain();

    // widest limits: only the largest norm and a zero norm fall outside
    sender_idle_pct = 86;
    set_limits(32'h0000_0000, 32'hFFFF_FFFF);
    queue_quat(-32768, -32768, -32768, -32768);
    queue_quat(0, 0, 0, 0);
    queue_quat(1, 0, 0, 0);
    queue_random_quats(330);
    wait_for_drain();

    // crossed limits
    set_limits(32'hFFFF_FFFF, 32'h0000_0000);
    queue_random_quats(20);
    wait_for_drain();

    // both limits on a unit norm
    set_limits(32'd67108864, 32'd67108864);
    queue_quat(8192, 0, 0, 0);
    queue_quat(0, 0, -8192, 0);
    queue_quat(8192, 1, 0, 0);
    queue_quat(8191, 0, 0, 0);
    queue_quat(4096, -4096, 4096, -4096);
    wait_for_drain();

    // zero limits: a zero norm still clears the flag
    set_limits(32'h0000_0000, 32'h0000_0000);
    queue_quat(0, 0, 0, 0);
    queue_quat(1, 0, 0, 0);
    wait_for_drain();

    // random limits, sender never idles
    sender_idle_pct = 0;
    set_limits($urandom_range(32'h0800_0000), $urandom_range(32'h4000_0000, 32'h0200_0000));
    queue_random_quats(330);
    wait_for_drain();

    // back to the reset values
    set_limits(NORM_LOW_RST, NORM_HIGH_RST);
    queue_random_quats(20);
    wait_for_drain();
    repeat (PIPE_LAT + 4) @(posedge clk);

    while (expected_matrices.size() != 0) begin
      void'(expected_matrices.pop_front());
      $display("expected result never arrived");
      error_count++;
    end
    $display("covered %0d quaternions (%0d zero norm, %0d inside limits), %0d matrices checked",
             quats_accepted, zero_norm_seen, in_limits_seen, matrices_checked);
    $display("limit registers written %0d times, including extreme and crossed settings",
             config_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/qrm_pkg.sv
hw/rtl/qrm_front.sv
hw/rtl/qrm_div_stage.sv
hw/rtl/quaternion_to_rotation_matrix_unit.sv
bench/quaternion_to_rotation_matrix_unit_tb.sv
